[rtl/core/hbd_pkg.sv]
// Shared types and constants for the HTTP body dechunker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hbd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam int CFG_ADDR_BITS       = 5;
    localparam int CFG_DATA_BITS       = 32;
    localparam int STATUS_BITS         = 10;
    localparam int COUNT_BITS          = 32;
    localparam int TRAIL_BYTES         = 2;

    localparam logic [STATUS_BITS-1:0] STATUS_INFO_LO    = 10'd100;
    localparam logic [STATUS_BITS-1:0] STATUS_INFO_HI    = 10'd199;
    localparam logic [STATUS_BITS-1:0] STATUS_OK         = 10'd200;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_CONTENT = 10'd204;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_MOD    = 10'd304;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        REG_REQ_IS_HEAD      = 3'd0,
        REG_RESP_STATUS      = 3'd1,
        REG_TRANSFER_CHUNKED = 3'd2,
        REG_LENGTH_PRESENT   = 3'd3,
        REG_BODY_LEN         = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_SKIP  = 3'd1,
        PH_DATA  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FRAMING = 2'd1,
        KIND_AFTER   = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic                   req_is_head;
        logic [STATUS_BITS-1:0] resp_status;
        logic                   transfer_chunked;
        logic                   length_present;
        logic [COUNT_BITS-1:0]  body_len;
    } hbd_cfg_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  body_complete;
        logic [COUNT_BITS-1:0] payload_total;
    } hbd_result_t;

endpackage

[rtl/core/hbd_cfg_regs.sv]
// APB-style configuration register bank for the HTTP body dechunker.
// Depends on hbd_pkg for register indexes and the config struct.
`timescale 1ns / 1ps

module hbd_cfg_regs
    import hbd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output hbd_cfg_t                 cfg
);

    hbd_cfg_t cfg_reg;
    logic     wr_en;
    cfg_reg_t reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.req_is_head      <= 1'b0;
            cfg_reg.resp_status      <= STATUS_OK;
            cfg_reg.transfer_chunked <= 1'b0;
            cfg_reg.length_present   <= 1'b0;
            cfg_reg.body_len         <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_REQ_IS_HEAD:      cfg_reg.req_is_head      <= pwdata[0];
                REG_RESP_STATUS:      cfg_reg.resp_status      <= pwdata[STATUS_BITS-1:0];
                REG_TRANSFER_CHUNKED: cfg_reg.transfer_chunked <= pwdata[0];
                REG_LENGTH_PRESENT:   cfg_reg.length_present   <= pwdata[0];
                REG_BODY_LEN:         cfg_reg.body_len         <= pwdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_REQ_IS_HEAD:      prdata = {31'd0, cfg_reg.req_is_head};
            REG_RESP_STATUS:      prdata = {22'd0, cfg_reg.resp_status};
            REG_TRANSFER_CHUNKED: prdata = {31'd0, cfg_reg.transfer_chunked};
            REG_LENGTH_PRESENT:   prdata = {31'd0, cfg_reg.length_present};
            REG_BODY_LEN:         prdata = cfg_reg.body_len;
            default:              prdata = '0;
        endcase
    end

endmodule

[rtl/core/hbd_parser.sv]
// Per-byte parse state and classification logic of the HTTP body dechunker.
// Depends on hbd_pkg; state advances once for every item that is processed.
`timescale 1ns / 1ps

module hbd_parser
    import hbd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [7:0]  body_byte,
    input  logic        first_byte,
    input  hbd_cfg_t    cfg,
    output hbd_result_t result
);

    phase_t                 phase_reg,  phase_next,  phase_cur;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next, remain_cur;
    logic [COUNT_BITS-1:0]  count_reg,  count_next,  count_cur;
    logic                   dseen_reg,  dseen_next,  dseen_cur;
    logic                   err_reg,    err_next,    err_cur;
    logic                   last_reg,   last_next,   last_cur;

    logic                   hex_ok;
    logic [3:0]             hex_val;
    logic                   no_body;
    logic                   len_oversize;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [63:0]            len_wide;
    kind_t                  kind;
    logic                   done;

    assign len_wide     = {{(64-COUNT_BITS){1'b0}}, cfg.body_len};
    assign len_oversize = (len_wide >> LENGTH_BITS) != 64'd0;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (body_byte inside {["0":"9"]}) begin
            hex_val = 4'(body_byte - 8'h30);
        end else if (body_byte inside {["a":"f"]}) begin
            hex_val = 4'(body_byte - 8'h57);
        end else if (body_byte inside {["A":"F"]}) begin
            hex_val = 4'(body_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        no_body = cfg.req_is_head ||
                  (cfg.resp_status inside {[STATUS_INFO_LO:STATUS_INFO_HI],
                                           STATUS_NO_CONTENT, STATUS_NOT_MOD});
    end

    // A new response starts from cleared state on its first byte.
    assign phase_cur  = first_byte ? PH_SIZE : phase_reg;
    assign remain_cur = first_byte ? '0      : remain_reg;
    assign count_cur  = first_byte ? '0      : count_reg;
    assign dseen_cur  = first_byte ? 1'b0    : dseen_reg;
    assign err_cur    = first_byte ? 1'b0    : err_reg;
    assign last_cur   = first_byte ? 1'b0    : last_reg;

    assign count_inc = (&count_cur) ? count_cur : count_cur + 1'b1;

    always_comb begin
        phase_next  = phase_cur;
        remain_next = remain_cur;
        count_next  = count_cur;
        dseen_next  = dseen_cur;
        err_next    = err_cur;
        last_next   = last_cur;
        kind        = KIND_FRAMING;
        done        = 1'b0;

        if (err_cur) begin
            kind = KIND_ERROR;
        end else if (no_body) begin
            kind = KIND_AFTER;
            done = 1'b1;
        end else if (cfg.transfer_chunked) begin
            case (phase_cur)
                PH_SIZE: begin
                    if (hex_ok) begin
                        if (remain_cur[LENGTH_BITS-1 -: 4] != 4'd0) begin
                            err_next = 1'b1;
                            kind     = KIND_ERROR;
                        end else begin
                            remain_next = {remain_cur[LENGTH_BITS-5:0], hex_val};
                            dseen_next  = 1'b1;
                        end
                    end else if (!dseen_cur) begin
                        if (body_byte != CHAR_SPACE && body_byte != CHAR_TAB) begin
                            err_next = 1'b1;
                            kind     = KIND_ERROR;
                        end
                    end else if (body_byte == CHAR_LF) begin
                        dseen_next = 1'b0;
                        if (remain_cur == '0) begin
                            last_next   = 1'b1;
                            remain_next = LENGTH_BITS'(TRAIL_BYTES);
                            phase_next  = PH_TRAIL;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (body_byte == CHAR_LF) begin
                        dseen_next = 1'b0;
                        if (remain_cur == '0) begin
                            last_next   = 1'b1;
                            remain_next = LENGTH_BITS'(TRAIL_BYTES);
                            phase_next  = PH_TRAIL;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    kind       = KIND_PAYLOAD;
                    count_next = count_inc;
                    if (remain_cur == LENGTH_BITS'(1)) begin
                        remain_next = LENGTH_BITS'(TRAIL_BYTES);
                        phase_next  = PH_TRAIL;
                    end else begin
                        remain_next = remain_cur - 1'b1;
                    end
                end
                PH_TRAIL: begin
                    remain_next = remain_cur - 1'b1;
                    if (remain_cur == LENGTH_BITS'(1)) begin
                        if (last_cur) begin
                            phase_next = PH_DONE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_SIZE;
                        end
                    end
                end
                PH_DONE: begin
                    kind = KIND_AFTER;
                    done = 1'b1;
                end
                default: begin
                    err_next = 1'b1;
                    kind     = KIND_ERROR;
                end
            endcase
        end else if (!cfg.length_present || len_oversize) begin
            err_next = 1'b1;
            kind     = KIND_ERROR;
        end else if (count_cur < cfg.body_len) begin
            count_next = count_cur + 1'b1;
            kind       = KIND_PAYLOAD;
            done       = (count_next == cfg.body_len);
        end else begin
            kind = KIND_AFTER;
            done = 1'b1;
        end
    end

    assign result.kind          = kind;
    assign result.body_complete = done && (kind != KIND_ERROR);
    assign result.payload_total = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIZE;
            remain_reg <= '0;
            count_reg  <= '0;
            dseen_reg  <= 1'b0;
            err_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
            dseen_reg  <= dseen_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
        end
    end

endmodule

[rtl/core/http_body_dechunker_core.sv]
// HTTP/1.1 response body decoder, top level: APB config, input and result stages.
// Depends on hbd_pkg, hbd_cfg_regs and hbd_parser.
`timescale 1ns / 1ps

// Takes one byte per item after the response header and returns one result per
// byte: the byte itself, its kind (payload, dropped framing, beyond the body or
// error), a body-complete flag and the running payload count. A byte is taken
// every clock cycle while the output is not stalled; each item passes an input
// register and then a result register before it is presented on the output. The
// parse state update between those two registers is combinational, so a new byte
// can be taken while the last one moves on. The user must write configuration
// through the APB port only while the stream is idle; the block does not enforce
// it. first_byte on an item restarts parsing for a new response.

module http_body_dechunker_core
    import hbd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] body_byte
    input  logic                     s_tuser,   // [0] first_byte

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [47:0]              m_tdata,   // [7:0] out_byte, [8] body_complete,
                                                // [40:9] payload_total, [47:41] zero
    output logic [1:0]               m_tuser    // [1:0] byte_kind
);

    hbd_cfg_t    cfg;
    hbd_result_t result;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    kind_t       out_kind_reg;
    logic        out_done_reg;
    logic [31:0] out_total_reg;

    logic        advance;

    hbd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .body_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .cfg        (cfg),
        .result     (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg  <= in_byte_reg;
            out_kind_reg  <= result.kind;
            out_done_reg  <= result.body_complete;
            out_total_reg <= result.payload_total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_done_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;

    a_error_not_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> !m_tdata[8])
        else $error("error item flagged as body complete");

    a_payload_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (m_tdata[40:9] != 32'd0))
        else $error("payload item with zero payload total");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!m_tvalid && !in_valid_reg))
        else $error("stages hold items right after reset");

endmodule

[tb/hbd_checker.sv]
// Scoreboard for the HTTP body dechunker: tracks APB writes, predicts every result item
// from the input items it sees accepted and compares the result channel against it.
// Depends on hbd_pkg.
`timescale 1ns / 1ps

module hbd_checker
    import hbd_pkg::*;
#(
    parameter int LB = LENGTH_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    input  logic                     pready,

    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] body_byte
    input  logic                     s_tuser,   // [0] first_byte

    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [47:0]              m_tdata,   // [7:0] out_byte, [8] body_complete,
                                                // [40:9] payload_total, [47:41] zero
    input  logic [1:0]               m_tuser,   // [1:0] byte_kind

    output int                       fail_count,
    output int                       outstanding,
    output int                       results_checked
);

    typedef struct packed {
        logic [7:0]            data;
        kind_t                 kind;
        logic                  body_done;
        logic [COUNT_BITS-1:0] total;
    } byte_verdict_t;

    hbd_cfg_t              resp_cfg;
    phase_t                dec_phase;
    logic [LB-1:0]         dec_left;
    logic [COUNT_BITS-1:0] dec_payload;
    logic                  dec_digit;
    logic                  dec_err;
    logic                  dec_last;

    byte_verdict_t         verdict_q[$];

    function automatic void clear_parse();
        dec_phase   = PH_SIZE;
        dec_left    = '0;
        dec_payload = '0;
        dec_digit   = 1'b0;
        dec_err     = 1'b0;
        dec_last    = 1'b0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void bump_payload();
        if (dec_payload != '1) dec_payload = dec_payload + 1'b1;
    endfunction

    function automatic void close_size_line();
        dec_digit = 1'b0;
        if (dec_left == '0) begin
            dec_last  = 1'b1;
            dec_left  = LB'(TRAIL_BYTES);
            dec_phase = PH_TRAIL;
        end else begin
            dec_phase = PH_DATA;
        end
    endfunction

    function automatic kind_t chunk_byte(input logic [7:0] b, output logic fin);
        int h;
        fin = 1'b0;
        h = hex_nibble(b);
        case (dec_phase)
            PH_SIZE: begin
                if (h >= 0) begin
                    if ((dec_left >> (LB - 4)) != '0) begin
                        dec_err = 1'b1;
                        return KIND_ERROR;
                    end
                    dec_left  = (dec_left << 4) | LB'(h);
                    dec_digit = 1'b1;
                    return KIND_FRAMING;
                end
                if (!dec_digit) begin
                    if (b == CHAR_SPACE || b == CHAR_TAB) return KIND_FRAMING;
                    dec_err = 1'b1;
                    return KIND_ERROR;
                end
                if (b == CHAR_LF) close_size_line();
                else dec_phase = PH_SKIP;
                return KIND_FRAMING;
            end
            PH_SKIP: begin
                if (b == CHAR_LF) close_size_line();
                return KIND_FRAMING;
            end
            PH_DATA: begin
                bump_payload();
                dec_left = dec_left - 1'b1;
                if (dec_left == '0) begin
                    dec_left  = LB'(TRAIL_BYTES);
                    dec_phase = PH_TRAIL;
                end
                return KIND_PAYLOAD;
            end
            PH_TRAIL: begin
                dec_left = dec_left - 1'b1;
                if (dec_left == '0) begin
                    if (dec_last) begin
                        dec_phase = PH_DONE;
                        fin = 1'b1;
                    end else begin
                        dec_phase = PH_SIZE;
                    end
                end
                return KIND_FRAMING;
            end
            PH_DONE: begin
                fin = 1'b1;
                return KIND_AFTER;
            end
            default: begin
                dec_err = 1'b1;
                return KIND_ERROR;
            end
        endcase
    endfunction

    function automatic byte_verdict_t decode_byte(input logic [7:0] b, input logic restart);
        byte_verdict_t v;
        kind_t         k;
        logic          fin;
        fin = 1'b0;
        if (restart) clear_parse();
        if (dec_err) begin
            k = KIND_ERROR;
        end else if (resp_cfg.req_is_head ||
                     (resp_cfg.resp_status >= STATUS_INFO_LO &&
                      resp_cfg.resp_status <= STATUS_INFO_HI) ||
                     resp_cfg.resp_status == STATUS_NO_CONTENT ||
                     resp_cfg.resp_status == STATUS_NOT_MOD) begin
            k   = KIND_AFTER;
            fin = 1'b1;
        end else if (resp_cfg.transfer_chunked) begin
            k = chunk_byte(b, fin);
        end else if (!resp_cfg.length_present ||
                     ((64'(resp_cfg.body_len) >> LB) != 64'd0)) begin
            dec_err = 1'b1;
            k = KIND_ERROR;
        end else if (dec_payload < resp_cfg.body_len) begin
            bump_payload();
            k   = KIND_PAYLOAD;
            fin = (dec_payload == resp_cfg.body_len);
        end else begin
            k   = KIND_AFTER;
            fin = 1'b1;
        end
        if (k == KIND_ERROR) fin = 1'b0;
        v.data      = b;
        v.kind      = k;
        v.body_done = fin;
        v.total     = dec_payload;
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 20)
            $display("mismatch on result %0d: %s got %0h, expected %0h",
                     results_checked, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        byte_verdict_t want;
        if (!aresetn) begin
            resp_cfg.req_is_head      = 1'b0;
            resp_cfg.resp_status      = STATUS_OK;
            resp_cfg.transfer_chunked = 1'b0;
            resp_cfg.length_present   = 1'b0;
            resp_cfg.body_len         = '0;
            clear_parse();
            verdict_q.delete();
            fail_count      = 0;
            results_checked = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]))
                    REG_REQ_IS_HEAD:      resp_cfg.req_is_head      = pwdata[0];
                    REG_RESP_STATUS:      resp_cfg.resp_status      = pwdata[STATUS_BITS-1:0];
                    REG_TRANSFER_CHUNKED: resp_cfg.transfer_chunked = pwdata[0];
                    REG_LENGTH_PRESENT:   resp_cfg.length_present   = pwdata[0];
                    REG_BODY_LEN:         resp_cfg.body_len         = pwdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(decode_byte(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected item", 64'(m_tdata), 64'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[7:0] !== want.data)
                        report_mismatch("out_byte", 64'(m_tdata[7:0]), 64'(want.data));
                    if (m_tuser !== want.kind)
                        report_mismatch("byte_kind", 64'(m_tuser), 64'(want.kind));
                    if (m_tdata[8] !== want.body_done)
                        report_mismatch("body_complete", 64'(m_tdata[8]), 64'(want.body_done));
                    if (m_tdata[40:9] !== want.total)
                        report_mismatch("payload_total", 64'(m_tdata[40:9]), 64'(want.total));
                    if (m_tdata[47:41] !== 7'd0)
                        report_mismatch("tdata padding", 64'(m_tdata[47:41]), 64'd0);
                end
                results_checked++;
            end
        end
        outstanding = verdict_q.size();
    end

endmodule

[tb/testbench.sv]
// Top of the dechunker testbench: clock, reset, APB setup, byte stimulus and random
// backpressure; hbd_checker does prediction and comparison and returns its fail count.
// Depends on hbd_pkg, hbd_checker and http_body_dechunker_core.
`timescale 1ns / 1ps

module testbench;
    import hbd_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 300;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [47:0]              m_tdata;
    logic [1:0]               m_tuser;

    int fail_count;
    int outstanding;
    int results_checked;

    bit src_gaps;
    bit sink_gaps;
    bit hold_req;
    int items_sent;
    int settings_used;
    int chunked_bodies;
    int length_bodies;

    logic [7:0] msg_q[$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    http_body_dechunker_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hbd_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    task automatic apb_write(input cfg_reg_t r, input logic [31:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_BITS'(r) << 2;
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Registers change only once every result has drained.
    task automatic apply_settings(input bit hd, input logic [9:0] st, input bit chunked,
                                  input bit lp, input logic [31:0] cl);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        apb_write(REG_REQ_IS_HEAD, 32'(hd));
        apb_write(REG_RESP_STATUS, 32'(st));
        apb_write(REG_TRANSFER_CHUNKED, 32'(chunked));
        apb_write(REG_LENGTH_PRESENT, 32'(lp));
        apb_write(REG_BODY_LEN, cl);
        settings_used++;
    endtask

    task automatic push_byte(input logic [7:0] b, input bit first);
        int gap;
        gap = src_gaps ? $urandom_range(0, 9) : 0;
        s_tvalid = 1'b0;
        repeat (gap) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        items_sent++;
    endtask

    task automatic send_text(input string txt, input bit first);
        for (int i = 0; i < txt.len(); i++) push_byte(txt[i], first && i == 0);
    endtask

    task automatic send_msg(input bit first);
        for (int i = 0; i < msg_q.size(); i++) push_byte(msg_q[i], first && i == 0);
    endtask

    task automatic fill_random(input int n);
        msg_q.delete();
        repeat (n) msg_q.push_back(8'($urandom));
    endtask

    task automatic add_size_line(input int size);
        logic [31:0] v;
        logic [3:0]  nib;
        logic [7:0]  ch;
        int          nd;
        v = size;
        repeat ($urandom_range(0, 2)) msg_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        nd = 1;
        while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
        if (nd < 8 && $urandom_range(0, 3) == 0) nd++;
        for (int i = nd - 1; i >= 0; i--) begin
            nib = 4'(v >> (4 * i));
            if (nib < 4'd10) ch = 8'h30 + 8'(nib);
            else ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
            msg_q.push_back(ch);
        end
        if ($urandom_range(0, 3) == 0) begin
            msg_q.push_back(";");
            repeat ($urandom_range(1, 5)) begin
                ch = 8'($urandom);
                msg_q.push_back(ch == CHAR_LF ? 8'h78 : ch);
            end
        end
        if ($urandom_range(0, 1)) msg_q.push_back(8'h0D);
        msg_q.push_back(CHAR_LF);
    endtask

    task automatic add_trailer();
        if ($urandom_range(0, 3) == 0) begin
            msg_q.push_back(8'($urandom));
            msg_q.push_back(8'($urandom));
        end else begin
            msg_q.push_back(8'h0D);
            msg_q.push_back(CHAR_LF);
        end
    endtask

    // Mostly well-formed chunked bodies; a few get a byte smashed or the tail cut.
    task automatic build_chunked();
        int size;
        int r;
        msg_q.delete();
        repeat ($urandom_range(0, 3)) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(1, 20);
            add_size_line(size);
            repeat (size) msg_q.push_back(8'($urandom));
            add_trailer();
        end
        add_size_line(0);
        add_trailer();
        repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
        r = $urandom_range(0, 9);
        if (r == 0) msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
        if (r == 1) begin
            size = $urandom_range(1, msg_q.size());
            while (msg_q.size() > size) void'(msg_q.pop_back());
        end
    endtask

    // Receiver: per-item stall, plus one long hold counted here.
    initial begin
        bit took;
        int stall_left;
        int hold_left;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            took = m_tvalid && m_tready;
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (took) stall_left = sink_gaps ? $urandom_range(0, 9) : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout: results still missing");
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int          start_items;
        int          mode;
        int          nresp;
        int          waited;
        bit          hd;
        bit          pressure_done;
        logic [9:0]  st;
        logic [31:0] cl;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        pressure_done = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: no length given, so errors that stick
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        apply_settings(1'b0, 10'd0, 1'b0, 1'b1, 32'd1);
        send_text("ab", 1'b1);
        apply_settings(1'b0, STATUS_OK, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_text("xy", 1'b1);
        apply_settings(1'b1, STATUS_OK, 1'b0, 1'b0, 32'd0);
        push_byte(8'h41, 1'b1);
        apply_settings(1'b0, STATUS_NO_CONTENT, 1'b0, 1'b0, 32'd0);
        push_byte(8'h42, 1'b1);
        apply_settings(1'b0, STATUS_NOT_MOD, 1'b1, 1'b1, 32'd5);
        push_byte(8'h43, 1'b1);
        apply_settings(1'b0, 10'd999, 1'b1, 1'b0, 32'd0);
        send_text("\t2;\nAB\r\n0\n\r\n", 1'b1);
        send_text("-", 1'b1);
        send_text("\n", 1'b1);
        send_text("FFFFFFFF0", 1'b1);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            mode      = $urandom_range(0, 9);
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            nresp     = $urandom_range(1, 3);
            hd        = 1'b0;
            cl = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40));
            if ($urandom_range(0, 15) == 0) cl = '1;
            case ($urandom_range(0, 5))
                0:       st = STATUS_OK;
                1:       st = 10'd0;
                2:       st = 10'd999;
                3:       st = 10'd99;
                4:       st = 10'd305;
                default: st = 10'($urandom_range(200, 999));
            endcase
            if (st == STATUS_NO_CONTENT || st == STATUS_NOT_MOD) st = STATUS_OK;

            if (!pressure_done && settings_used >= 12) begin
                // receiver holds off while the sender streams back to back
                pressure_done = 1'b1;
                apply_settings(1'b0, STATUS_OK, 1'b0, 1'b1, 32'hFFFF_FFFF);
                src_gaps = 1'b0;
                hold_req = 1'b1;
                fill_random(160);
                send_msg(1'b1);
                length_bodies++;
            end else begin
                case (mode)
                    0, 1, 2, 3, 4: begin
                        apply_settings(1'b0, st, 1'b1, 1'($urandom), cl);
                        repeat (nresp) begin
                            build_chunked();
                            send_msg($urandom_range(0, 7) != 0);
                            chunked_bodies++;
                        end
                    end
                    5, 6: begin
                        apply_settings(1'b0, st, 1'b0, 1'b1, cl);
                        repeat (nresp) begin
                            fill_random((cl > 40) ? $urandom_range(1, 30)
                                                  : int'(cl) + $urandom_range(1, 3));
                            send_msg($urandom_range(0, 7) != 0);
                            length_bodies++;
                        end
                    end
                    7: begin
                        apply_settings(1'b0, st, 1'b0, 1'b0, cl);
                        fill_random($urandom_range(1, 8));
                        send_msg(1'b1);
                    end
                    8: begin
                        case ($urandom_range(0, 5))
                            0:       st = STATUS_INFO_LO;
                            1:       st = STATUS_INFO_HI;
                            2:       st = 10'($urandom_range(100, 199));
                            3:       st = STATUS_NO_CONTENT;
                            4:       st = STATUS_NOT_MOD;
                            default: hd = 1'b1;
                        endcase
                        apply_settings(hd, st, 1'($urandom), 1'($urandom), cl);
                        fill_random($urandom_range(1, 10));
                        send_msg($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        apply_settings(1'($urandom), 10'($urandom_range(0, 999)),
                                       1'($urandom), 1'($urandom), cl);
                        if ($urandom_range(0, 1)) build_chunked();
                        else fill_random($urandom_range(1, 30));
                        send_msg($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end

        waited = 0;
        while (outstanding != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (10) @(negedge aclk);
        if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
        $display("stimulus: %0d bytes under %0d register settings, %0d chunked and %0d length bodies",
                 items_sent, settings_used, chunked_bodies, length_bodies);
        $display("checked %0d result items, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
